[hw/rtl/kmcd_pkg.sv]
// Shared constants for the key matrix change detector.
// Used by the channel interfaces, the merge stage, the top level and the checker.
package kmcd_pkg;

  localparam int unsigned SNAP_W      = 64;  // snapshot beat width
  localparam int unsigned ROW_STRIDE  = 8;   // snapshot bits per column
  localparam int unsigned KEY_W       = 6;   // key number width
  localparam int unsigned CFG_W       = 4;   // widest configuration register
  localparam int unsigned CFG_IDX_W   = 1;   // configuration index width
  localparam int unsigned MAX_ROWS    = 8;
  localparam int unsigned MAX_COLUMNS = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST    = 4'd8;
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = 4'd8;

endpackage

[hw/rtl/kmcd_snap_if.sv]
// Snapshot channel: valid/ready handshake carrying one matrix snapshot.
// Depends on kmcd_pkg for the beat width.
interface kmcd_snap_if;
  logic                        valid;
  logic                        ready;
  logic [kmcd_pkg::SNAP_W-1:0] matrix_snapshot;

  modport source (output valid, output matrix_snapshot, input ready);
  modport sink   (input valid, input matrix_snapshot, output ready);
endinterface

[hw/rtl/kmcd_event_if.sv]
// Event channel: valid/ready handshake carrying one key press or release event.
// Depends on kmcd_pkg for the key number width.
interface kmcd_event_if;
  logic                       valid;
  logic                       ready;
  logic                       pressed;
  logic [kmcd_pkg::KEY_W-1:0] key_number;
  logic                       last_event;

  modport source (output valid, output pressed, output key_number, output last_event,
                  input ready);
  modport sink   (input valid, input pressed, input key_number, input last_event,
                  output ready);
endinterface

[hw/rtl/kmcd_lane.sv]
// One column lane: holds the column's previous row bits and finds changed keys.
// Depends on kmcd_pkg only through the parameter defaults of the top level.
module kmcd_lane #(
  parameter int unsigned MAX_ROWS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                commit_i,   // snapshot changed the combined word
  input  logic                in_use_i,   // column is within column_count
  input  logic [MAX_ROWS-1:0] mask_i,     // rows in use
  input  logic [MAX_ROWS-1:0] col_bits_i, // this column's snapshot rows
  output logic [MAX_ROWS-1:0] diff_o,
  output logic [MAX_ROWS-1:0] level_o
);

  logic [MAX_ROWS-1:0] prev_q, prev_d;
  logic [MAX_ROWS-1:0] now;

  assign now     = col_bits_i & mask_i;
  assign diff_o  = (now ^ prev_q) & mask_i & {MAX_ROWS{in_use_i}};
  assign level_o = now;

  always_comb begin
    prev_d = prev_q;
    // unused rows stay at the released level
    if (commit_i && in_use_i) begin
      prev_d = now | ~mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '1;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

[hw/rtl/kmcd_merge.sv]
// Merge stage: gathers changed lane keys; one event per cycle unless stalled.
// Depends on kmcd_pkg and kmcd_event_if.
module kmcd_merge #(
  parameter int unsigned MAX_ROWS    = 8,
  parameter int unsigned MAX_COLUMNS = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    load_i,
  input  logic [MAX_COLUMNS-1:0][MAX_ROWS-1:0]    diff_i,
  input  logic [MAX_COLUMNS-1:0][MAX_ROWS-1:0]    level_i,
  input  logic [kmcd_pkg::CFG_W-1:0]              rows_i,
  output logic                                    busy_o,
  kmcd_event_if.source                            evt_o
);

  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [MAX_COLUMNS-1:0][MAX_ROWS-1:0] pend_q, pend_d;
  logic [MAX_COLUMNS-1:0][MAX_ROWS-1:0] level_q;
  logic                                 out_valid_q, out_valid_d;
  logic                                 pressed_q;
  logic [kmcd_pkg::KEY_W-1:0]           key_q;
  logic                                 last_q;

  logic                                 has_pend;
  logic                                 advance;
  logic [CW-1:0]                        col_sel;
  logic [RW-1:0]                        row_sel;
  logic [MAX_COLUMNS-1:0][MAX_ROWS-1:0] pend_left;
  logic [kmcd_pkg::KEY_W-1:0]           key_d;

  assign has_pend = |pend_q;
  assign busy_o   = has_pend;
  assign advance  = has_pend && (!out_valid_q || evt_o.ready);

  // lowest column with a pending key, then lowest row in it
  always_comb begin
    col_sel = '0;
    for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
      if (|pend_q[c]) col_sel = CW'(c);
    end
  end

  always_comb begin
    row_sel = '0;
    for (int r = MAX_ROWS - 1; r >= 0; r--) begin
      if (pend_q[col_sel][r]) row_sel = RW'(r);
    end
  end

  always_comb begin
    pend_left                   = pend_q;
    pend_left[col_sel][row_sel] = 1'b0;
  end

  assign key_d = kmcd_pkg::KEY_W'(kmcd_pkg::KEY_W'(col_sel) * kmcd_pkg::KEY_W'(rows_i))
               + kmcd_pkg::KEY_W'(row_sel);

  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (load_i) begin
      pend_d = diff_i;
    end else if (advance) begin
      pend_d = pend_left;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (evt_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      level_q <= level_i;
    end
    if (advance) begin
      pressed_q <= !level_q[col_sel][row_sel];
      key_q     <= key_d;
      last_q    <= (pend_left == '0);
    end
  end

  assign evt_o.valid      = out_valid_q;
  assign evt_o.pressed    = pressed_q;
  assign evt_o.key_number = key_q;
  assign evt_o.last_event = last_q;

endmodule

[hw/rtl/key_matrix_change_detector_core.sv]
// Channel   Dir  Handshake        Payload
// snap_i    in   valid/ready      matrix_snapshot[63:0]
// evt_o     out  valid/ready      pressed, key_number[5:0], last_event
// cfg       in   cfg_we_i         cfg_index_i, cfg_wdata_i[3:0]
//
// A snapshot is taken whenever no events are pending; its events leave one per
// cycle while the receiver is ready (up to 64 per snapshot) through the merge
// stage's single event register, and a snapshot that changes nothing makes no
// events. A new snapshot is taken once the last event of the previous one sits
// in the output register. Reset restores all keys released and both counts to 8;
// a stalled event holds the output register.
module key_matrix_change_detector_core #(
  parameter int unsigned MAX_ROWS    = kmcd_pkg::MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = kmcd_pkg::MAX_COLUMNS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kmcd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kmcd_pkg::CFG_W-1:0]     cfg_wdata_i,
  kmcd_snap_if.sink                      snap_i,
  kmcd_event_if.source                   evt_o
);

  logic [kmcd_pkg::CFG_W-1:0]           row_count_q, column_count_q;
  logic [kmcd_pkg::CFG_W-1:0]           rows_eff, cols_eff;
  logic [MAX_ROWS-1:0]                  mask;
  logic [MAX_ROWS-1:0]                  combined;
  logic [MAX_ROWS-1:0]                  combined_q, combined_d;
  logic                                 accept, commit, busy;
  logic [MAX_COLUMNS-1:0][MAX_ROWS-1:0] lane_diff, lane_level;

  // out-of-range counts clamp to 1..max
  always_comb begin
    rows_eff = row_count_q;
    if (row_count_q == '0) begin
      rows_eff = kmcd_pkg::CFG_W'(1);
    end else if (row_count_q > kmcd_pkg::CFG_W'(MAX_ROWS)) begin
      rows_eff = kmcd_pkg::CFG_W'(MAX_ROWS);
    end
    cols_eff = column_count_q;
    if (column_count_q == '0) begin
      cols_eff = kmcd_pkg::CFG_W'(1);
    end else if (column_count_q > kmcd_pkg::CFG_W'(MAX_COLUMNS)) begin
      cols_eff = kmcd_pkg::CFG_W'(MAX_COLUMNS);
    end
  end

  always_comb begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      mask[r] = (kmcd_pkg::CFG_W'(r) < rows_eff);
    end
  end

  always_comb begin
    combined = mask;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (kmcd_pkg::CFG_W'(c) < cols_eff) begin
        combined = combined & snap_i.matrix_snapshot[c*kmcd_pkg::ROW_STRIDE +: MAX_ROWS];
      end
    end
  end

  assign snap_i.ready = !busy;
  assign accept       = snap_i.valid && snap_i.ready;
  assign commit       = accept && (combined != (combined_q & mask));
  assign combined_d   = commit ? (combined | ~mask) : combined_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= kmcd_pkg::ROW_COUNT_RST;
      column_count_q <= kmcd_pkg::COLUMN_COUNT_RST;
      combined_q     <= '1;
    end else begin
      combined_q <= combined_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          kmcd_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_wdata_i;
          kmcd_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_lane
    kmcd_lane #(
      .MAX_ROWS (MAX_ROWS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .commit_i   (commit),
      .in_use_i   (kmcd_pkg::CFG_W'(c) < cols_eff),
      .mask_i     (mask),
      .col_bits_i (snap_i.matrix_snapshot[c*kmcd_pkg::ROW_STRIDE +: MAX_ROWS]),
      .diff_o     (lane_diff[c]),
      .level_o    (lane_level[c])
    );
  end

  kmcd_merge #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (commit),
    .diff_i  (lane_diff),
    .level_i (lane_level),
    .rows_i  (rows_eff),
    .busy_o  (busy),
    .evt_o   (evt_o)
  );

endmodule

[hw/rtl/kmcd_checker.sv]
// Port-level checks for the key matrix change detector, bound to the top level.
// Depends on key_matrix_change_detector_core and its channel interfaces.
module kmcd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_pressed_i,
  input logic [kmcd_pkg::KEY_W-1:0] out_key_i,
  input logic                       out_last_i
);

  // a stalled event beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pressed_i)
                                   && $stable(out_key_i) && $stable(out_last_i))
    else $error("stalled event beat changed");

  // no snapshot while a snapshot still has events beyond the shown one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !(in_valid_i && in_ready_i))
    else $error("snapshot taken in the middle of an event burst");

  // a taken beat that is not the last is followed by the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("event burst broken off before its last beat");

  // nothing leaves during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("event beat shown during reset");

endmodule

bind key_matrix_change_detector_core kmcd_checker u_kmcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (snap_i.valid),
  .in_ready_i    (snap_i.ready),
  .out_valid_i   (evt_o.valid),
  .out_ready_i   (evt_o.ready),
  .out_pressed_i (evt_o.pressed),
  .out_key_i     (evt_o.key_number),
  .out_last_i    (evt_o.last_event)
);

[tb/key_matrix_change_detector_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for key_matrix_change_detector_core: drives matrix snapshots,
// predicts the press/release events, and checks every event beat in order.
// Depends on kmcd_pkg and the kmcd_snap_if / kmcd_event_if channel interfaces.
module key_matrix_change_detector_core_tb;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 15;

  typedef struct packed {
    logic                       pressed;
    logic [kmcd_pkg::KEY_W-1:0] key_number;
    logic                       last_event;
  } key_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [kmcd_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [kmcd_pkg::CFG_W-1:0]     cfg_wdata_i;

  kmcd_snap_if  snap ();
  kmcd_event_if evt ();

  key_matrix_change_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .snap_i      (snap),
    .evt_o       (evt)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // predictor state
  logic [kmcd_pkg::CFG_W-1:0] row_cnt;
  logic [kmcd_pkg::CFG_W-1:0] col_cnt;
  logic [7:0]                 prev_rows [kmcd_pkg::MAX_COLUMNS];
  logic [7:0]                 comb_rows;

  logic [kmcd_pkg::SNAP_W-1:0] pending_scans [$];
  key_event_t                  expected_events [$];
  logic [kmcd_pkg::SNAP_W-1:0] scan_img;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt;
  bit          failed;

  function automatic int unsigned rows_used();
    if (row_cnt == 0) return 1;
    if (row_cnt > kmcd_pkg::MAX_ROWS) return kmcd_pkg::MAX_ROWS;
    return row_cnt;
  endfunction

  function automatic int unsigned cols_used();
    if (col_cnt == 0) return 1;
    if (col_cnt > kmcd_pkg::MAX_COLUMNS) return kmcd_pkg::MAX_COLUMNS;
    return col_cnt;
  endfunction

  // Work out the events one accepted snapshot causes and queue them.
  function automatic void predict_key_events(input logic [kmcd_pkg::SNAP_W-1:0] scan);
    int unsigned rows;
    int unsigned cols;
    logic [7:0]  mask;
    logic [7:0]  comb;
    logic [7:0]  now;
    logic [7:0]  diff;
    key_event_t  held;
    bit          held_valid;
    rows = rows_used();
    cols = cols_used();
    mask = 8'((9'd1 << rows) - 9'd1);
    comb = mask;
    held_valid = 1'b0;
    held = '0;
    for (int unsigned c = 0; c < cols; c++) begin
      comb &= scan[c*kmcd_pkg::ROW_STRIDE +: 8];
    end
    if (comb == (comb_rows & mask)) return;
    comb_rows = comb | ~mask;
    for (int unsigned c = 0; c < cols; c++) begin
      now  = scan[c*kmcd_pkg::ROW_STRIDE +: 8] & mask;
      diff = (now ^ prev_rows[c]) & mask;
      for (int unsigned r = 0; r < rows; r++) begin
        if (diff[r]) begin
          if (held_valid) expected_events.push_back(held);
          held.pressed    = ~now[r];
          held.key_number = kmcd_pkg::KEY_W'(c * rows + r);
          held.last_event = 1'b0;
          held_valid      = 1'b1;
        end
      end
      prev_rows[c] = now | ~mask;
    end
    // flag the final event of the snapshot
    if (held_valid) begin
      held.last_event = 1'b1;
      expected_events.push_back(held);
    end
  endfunction

  // Mostly a few keys pressed or released at a time, with some noise.
  function automatic logic [kmcd_pkg::SNAP_W-1:0] next_scan();
    int unsigned pick;
    int unsigned flips;
    int unsigned c;
    int unsigned r;
    pick = $urandom_range(99);
    if (pick < 10) begin
      scan_img = {$urandom, $urandom};
    end else if (pick < 16) begin
      scan_img = '1;
    end else if (pick >= 26) begin
      flips = $urandom_range(1, 3);
      for (int unsigned i = 0; i < flips; i++) begin
        c = $urandom_range(cols_used() - 1);
        r = $urandom_range(rows_used() - 1);
        scan_img[c*kmcd_pkg::ROW_STRIDE + r] = ~scan_img[c*kmcd_pkg::ROW_STRIDE + r];
      end
      // toggle any bit, unused rows and columns included
      if ($urandom_range(3) == 0) begin
        c = $urandom_range(kmcd_pkg::SNAP_W - 1);
        scan_img[c] = ~scan_img[c];
      end
    end
    return scan_img;
  endfunction

  task automatic write_reg(input logic [kmcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kmcd_pkg::CFG_W-1:0]     val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == kmcd_pkg::CFG_ROW_COUNT) row_cnt = val;
    else row_cnt = row_cnt;
    if (idx == kmcd_pkg::CFG_COLUMN_COUNT) col_cnt = val;
  endtask

  // Hold until every snapshot is taken and every event has arrived, then let
  // the block drain.
  task automatic settle();
    while (pending_scans.size() != 0 || snap.valid || expected_events.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // snapshot driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      snap.valid <= 1'b0;
    end else begin
      if (snap.valid && snap.ready) predict_key_events(snap.matrix_snapshot);
      if (!snap.valid || snap.ready) begin
        if (pending_scans.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          snap.valid           <= 1'b1;
          snap.matrix_snapshot <= pending_scans.pop_front();
        end else begin
          snap.valid <= 1'b0;
        end
      end
    end
  end

  // event monitor
  always @(posedge clk_i) begin
    key_event_t want;
    if (!rst_ni) begin
      evt.ready <= 1'b0;
    end else begin
      if (evt.valid && evt.ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event: pressed %0b key_number %0d last_event %0b",
                 evt.pressed, evt.key_number, evt.last_event);
          failed = 1'b1;
        end else begin
          want = expected_events.pop_front();
          if (evt.pressed !== want.pressed) begin
            $error("pressed mismatch: expected %0b, actual %0b", want.pressed, evt.pressed);
            failed = 1'b1;
          end
          if (evt.key_number !== want.key_number) begin
            $error("key_number mismatch: expected %0d, actual %0d",
                   want.key_number, evt.key_number);
            failed = 1'b1;
          end
          if (evt.last_event !== want.last_event) begin
            $error("last_event mismatch: expected %0b, actual %0b",
                   want.last_event, evt.last_event);
            failed = 1'b1;
          end
        end
      end
      evt.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [kmcd_pkg::CFG_W-1:0] phase_rows [NUM_PHASES];
    logic [kmcd_pkg::CFG_W-1:0] phase_cols [NUM_PHASES];
    int unsigned                idle_tab   [4];
    int unsigned                stall_tab  [4];
    phase_rows = '{4'd1, 4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd6};
    phase_cols = '{4'd1, 4'd1, 4'd8, 4'd15, 4'd0, 4'd5, 4'd8, 4'd7};
    idle_tab   = '{0, 48, 0, 33};
    stall_tab  = '{0, 0, 48, 33};

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = kmcd_pkg::CFG_ROW_COUNT;
    cfg_wdata_i          = '0;
    snap.valid           = 1'b0;
    snap.matrix_snapshot = '1;
    evt.ready            = 1'b0;
    cycle_cnt            = 0;
    failed               = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    row_cnt              = kmcd_pkg::ROW_COUNT_RST;
    col_cnt              = kmcd_pkg::COLUMN_COUNT_RST;
    comb_rows            = 8'hFF;
    scan_img             = '1;
    foreach (prev_rows[c]) prev_rows[c] = 8'hFF;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed snapshots at the reset counts
    pending_scans.push_back(64'hFFFF_FFFF_FFFF_FFFF); // matches reset state
    pending_scans.push_back(64'h0000_0000_0000_0000); // every key pressed
    pending_scans.push_back(64'hFFFF_FFFF_FFFF_FFFF); // every key released
    pending_scans.push_back(64'hFFFF_FFFF_FFFF_FFFE); // lowest key
    pending_scans.push_back(64'h7FFF_FFFF_FFFF_FFFE); // highest key too
    // same combined word, different keys: no events
    pending_scans.push_back(64'h7FFF_FFFF_FFFF_FEFF);
    pending_scans.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_scans.push_back(64'h5555_5555_5555_5555);
    pending_scans.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_scans.push_back(64'hFFFF_FFFF_FFFF_FF00); // first column held down
    pending_scans.push_back(64'h00FF_FFFF_FFFF_FFFF); // last column held down
    pending_scans.push_back(64'hFEFD_FBF7_EFDF_BF7F); // diagonal
    pending_scans.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    settle();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      write_reg(kmcd_pkg::CFG_ROW_COUNT, phase_rows[p]);
      write_reg(kmcd_pkg::CFG_COLUMN_COUNT, phase_cols[p]);
      send_idle_pct  = idle_tab[p % 4];
      recv_stall_pct = stall_tab[p % 4];
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) pending_scans.push_back(next_scan());
      settle();
    end

    if (failed) begin
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/kmcd_pkg.sv
hw/rtl/kmcd_snap_if.sv
hw/rtl/kmcd_event_if.sv
hw/rtl/kmcd_lane.sv
hw/rtl/kmcd_merge.sv
hw/rtl/key_matrix_change_detector_core.sv
hw/rtl/kmcd_checker.sv
tb/key_matrix_change_detector_core_tb.sv
